// ===== hdl/cnv_pkg.sv =====
// Shared constants, types and command/status structs for the 3x3 convolution block.
`default_nettype none
package cnv_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COEF_BITS  = 16;

    localparam int KSIZE     = 3;
    localparam int TAPS      = KSIZE * KSIZE;
    localparam int PIX_W     = 8;
    localparam int FRAC_W    = 8;
    localparam int DIM_W     = 12;
    localparam int KROW_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 11;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int EWC_W = COL_W + 1;
    localparam int EWR_W = ROW_W + 1;

    localparam int Q_W    = 16;
    localparam int VAL_W  = Q_W + 1;
    localparam int VAL_MAX = 255 << FRAC_W;

    localparam int PROD_W = COEF_BITS + PIX_W + 1;
    localparam int SUM_W  = PROD_W + 4;
    localparam int SABS_W = COEF_BITS + 4;
    localparam int DIVR_W = SABS_W + 1;
    localparam int DVD_W  = SUM_W + FRAC_W + 2;

    localparam int TAP_W = $clog2(TAPS + 1);
    localparam int CNT_W = $clog2((Q_W > TAPS + 1) ? Q_W : TAPS + 1);

    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_KTOP   = 3'd2,
        CFG_KMID   = 3'd3,
        CFG_KBOT   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_NORM,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0]             width;
        logic [DIM_W-1:0]             height;
        logic [KSIZE-1:0][KROW_W-1:0] krow;
    } t_cfg;

    typedef struct packed {
        logic             accept;
        logic             load_win;
        logic             mac_clr;
        logic             mac_en;
        logic             acc_en;
        logic             norm;
        logic             div_step;
        logic             emit;
        logic [TAP_W-1:0] tap;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/conv3x3_normalized_stream.sv =====
// Top level of the 3x3 normalized convolution over a raster pixel stream.
// Usage:
//   Input channel: i_in_valid / o_in_stall / i_pixel, 8-bit gray pixels in raster
//   order; a transaction completes when valid is high and stall is low.
//   Output channel: o_out_valid / i_out_stall with row, column, signed Q8.8 value
//   and frame_last, one transaction per interior pixel (border pixels give none).
//   Config channel: i_cfg_valid / o_cfg_ready (always high), index 0 width,
//   1 height, 2..4 kernel rows; other indexes are ignored. Write only when idle.
// Timing:
//   A border pixel passes through accept and window load only. An interior pixel
//   goes through accept, window load, the MAC loop through one shared multiplier,
//   normalize and 16 restoring-divider steps before its result is ready; the
//   serial divider and MAC loop set the rate. The result for (i, j) comes with
//   the transaction of pixel (i+1, j+1).
// Reset and stall:
//   Synchronous reset clears position counters, state and config to 640x480 with
//   a zero kernel; the line stores need no clearing. A stalled result holds in
//   the output register while the next pixel is taken; a finished result waits
//   in the controller until the register frees.
`default_nettype none
module conv3x3_normalized_stream (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [cnv_pkg::PIX_W-1:0]      i_pixel,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [cnv_pkg::POS_W-1:0]           o_out_row,
    output logic [cnv_pkg::POS_W-1:0]           o_out_col,
    output logic signed [cnv_pkg::VAL_W-1:0]    o_value,
    output logic                                o_frame_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cnv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cnv_pkg::KROW_W-1:0]     i_cfg_data
);
    import cnv_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    cnv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cnv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cnv_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg        (cfg),
        .i_pixel      (i_pixel),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_value      (o_value),
        .o_frame_last (o_frame_last)
    );

endmodule
`default_nettype wire

// ===== hdl/cnv_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
`default_nettype none
module cnv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/cnv_cfg.sv =====
// Configuration register file: frame size and kernel rows.
`default_nettype none
module cnv_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cnv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cnv_pkg::KROW_W-1:0]     i_cfg_data,
    output cnv_pkg::t_cfg                       o_cfg
);
    import cnv_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.krow   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg.width   <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height  <= i_cfg_data[DIM_W-1:0];
                CFG_KTOP:   r_cfg.krow[0] <= i_cfg_data;
                CFG_KMID:   r_cfg.krow[1] <= i_cfg_data;
                CFG_KBOT:   r_cfg.krow[2] <= i_cfg_data;
                default:    r_cfg         <= r_cfg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cnv_ctrl.sv =====
// Controller state machine: sequences accept, window load, MAC, normalize, divide, emit.
`default_nettype none
module cnv_ctrl (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  cnv_pkg::t_stat i_stat,
    output cnv_pkg::t_cmd  o_cmd
);
    import cnv_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_cnt   = '0;
                n_state = i_stat.interior ? ST_MAC : ST_IDLE;
            end
            ST_MAC: begin
                if (r_cnt == CNT_W'(TAPS)) begin
                    n_cnt   = '0;
                    n_state = ST_NORM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_NORM: begin
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_LOAD: begin
                o_cmd.load_win = 1'b1;
                o_cmd.mac_clr  = 1'b1;
            end
            ST_MAC: begin
                o_cmd.mac_en = (r_cnt < CNT_W'(TAPS));
                o_cmd.acc_en = (r_cnt != '0);
                o_cmd.tap    = TAP_W'(r_cnt);
            end
            ST_NORM: begin
                o_cmd.norm = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/cnv_dp.sv =====
// Datapath: position counters, line stores, window, MAC, restoring divider, output register.
`default_nettype none
module cnv_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  cnv_pkg::t_cmd                     i_cmd,
    output cnv_pkg::t_stat                    o_stat,
    input  cnv_pkg::t_cfg                     i_cfg,
    input  wire logic [cnv_pkg::PIX_W-1:0]    i_pixel,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic [cnv_pkg::POS_W-1:0]         o_out_row,
    output logic [cnv_pkg::POS_W-1:0]         o_out_col,
    output logic signed [cnv_pkg::VAL_W-1:0]  o_value,
    output logic                              o_frame_last
);
    import cnv_pkg::*;

    localparam int KEXT_W = KROW_W + KSIZE * COEF_BITS;

    // frame size
    logic [EWC_W-1:0] w_eff;
    logic [EWR_W-1:0] h_eff;

    always_comb begin
        if (i_cfg.width < DIM_W'(3)) begin
            w_eff = EWC_W'(3);
        end else if (i_cfg.width > MAX_WIDTH) begin
            w_eff = EWC_W'(MAX_WIDTH);
        end else begin
            w_eff = EWC_W'(i_cfg.width);
        end
        if (i_cfg.height < DIM_W'(3)) begin
            h_eff = EWR_W'(3);
        end else if (i_cfg.height > MAX_HEIGHT) begin
            h_eff = EWR_W'(MAX_HEIGHT);
        end else begin
            h_eff = EWR_W'(i_cfg.height);
        end
    end

    // position of the next pixel
    logic [COL_W-1:0] r_col, n_col, cur_c, r_c;
    logic [ROW_W-1:0] r_row, n_row, cur_r, r_r;
    logic [EWC_W-1:0] c_ext, c_inc;
    logic [EWR_W-1:0] r_ext, r_inc;
    logic [PIX_W-1:0] r_px;

    always_comb begin
        c_ext = {1'b0, r_col};
        r_ext = {1'b0, r_row};
        if (c_ext >= w_eff) begin
            c_ext = '0;
            r_ext = r_ext + 1'b1;
        end
        if (r_ext >= h_eff) begin
            r_ext = '0;
        end
        cur_c = c_ext[COL_W-1:0];
        cur_r = r_ext[ROW_W-1:0];
        c_inc = c_ext + 1'b1;
        r_inc = r_ext;
        if (c_inc >= w_eff) begin
            c_inc = '0;
            r_inc = r_ext + 1'b1;
            if (r_inc >= h_eff) begin
                r_inc = '0;
            end
        end
        n_col = c_inc[COL_W-1:0];
        n_row = r_inc[ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c  <= cur_c;
            r_r  <= cur_r;
            r_px <= i_pixel;
        end
    end

    // line stores, one bank per row parity
    logic [PIX_W-1:0] rd0, rd1, ls_cur, ls_prev;

    cnv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept & ~cur_r[0]),
        .i_waddr (cur_c),
        .i_wdata (i_pixel),
        .i_raddr (cur_c),
        .o_rdata (rd0)
    );

    cnv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept & cur_r[0]),
        .i_waddr (cur_c),
        .i_wdata (i_pixel),
        .i_raddr (cur_c),
        .o_rdata (rd1)
    );

    assign ls_cur  = r_r[0] ? rd1 : rd0;
    assign ls_prev = r_r[0] ? rd0 : rd1;

    // window, entry a*KSIZE+b: row a (0 = oldest), column b (0 = oldest)
    logic [PIX_W-1:0] r_win [TAPS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_win) begin
            for (int a = 0; a < KSIZE; a++) begin
                for (int b = 0; b < KSIZE - 1; b++) begin
                    r_win[a*KSIZE+b] <= r_win[a*KSIZE+b+1];
                end
            end
            r_win[KSIZE-1]         <= ls_cur;
            r_win[2*KSIZE-1]       <= ls_prev;
            r_win[KSIZE*KSIZE-1]   <= r_px;
        end
    end

    assign o_stat.interior = (r_r >= ROW_W'(2)) && (r_c >= COL_W'(2));

    // coefficients, flipped kernel: tap t uses window entry TAPS-1-t
    logic signed [COEF_BITS-1:0] coef [TAPS];
    logic [KEXT_W-1:0]           krow_ext;
    logic signed [COEF_BITS-1:0] sel_coef;
    logic [PIX_W-1:0]            sel_pix;
    logic signed [COEF_BITS:0]   coef_sx;
    logic [COEF_BITS:0]          coef_abs;

    always_comb begin
        krow_ext = '0;
        for (int kr = 0; kr < KSIZE; kr++) begin
            krow_ext = KEXT_W'(i_cfg.krow[kr]);
            for (int kc = 0; kc < KSIZE; kc++) begin
                coef[kr*KSIZE+kc] = krow_ext[kc*COEF_BITS +: COEF_BITS];
            end
        end
    end

    always_comb begin
        sel_coef = '0;
        sel_pix  = '0;
        for (int i = 0; i < TAPS; i++) begin
            if (i_cmd.tap == TAP_W'(i)) begin
                sel_coef = coef[i];
                sel_pix  = r_win[TAPS-1-i];
            end
        end
        coef_sx  = {sel_coef[COEF_BITS-1], sel_coef};
        coef_abs = coef_sx[COEF_BITS] ? -coef_sx : coef_sx;
    end

    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SABS_W-1:0]        r_sabs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_clr) begin
            r_sum  <= '0;
            r_sabs <= '0;
        end else begin
            if (i_cmd.mac_en) begin
                r_prod <= sel_coef * $signed({1'b0, sel_pix});
                r_sabs <= r_sabs + SABS_W'(coef_abs);
            end
            if (i_cmd.acc_en) begin
                r_sum <= r_sum + SUM_W'(r_prod);
            end
        end
    end

    // round(256 * |sum| / S): q = (2n + S) / (2S), one quotient bit per step
    logic [SUM_W-1:0]  mag;
    logic [DVD_W-1:0]  dvd;
    logic [DIVR_W-1:0] r_rem, r_div;
    logic [Q_W-1:0]    r_quo;
    logic              r_neg, r_zero;
    logic [DIVR_W:0]   trial, diff;
    logic              ge;

    assign mag   = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign dvd   = (DVD_W'(mag) << (FRAC_W + 1)) + DVD_W'(r_sabs);
    assign trial = {r_rem, r_quo[Q_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm) begin
            r_rem  <= dvd[Q_W +: DIVR_W];
            r_quo  <= dvd[Q_W-1:0];
            r_div  <= {r_sabs, 1'b0};
            r_neg  <= r_sum[SUM_W-1];
            r_zero <= (r_sabs == '0);
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], ge};
        end
    end

    // output register
    logic signed [VAL_W-1:0] q_sx, val;
    logic                    last;

    assign q_sx = $signed({1'b0, r_quo});
    assign val  = r_zero ? '0 : (r_neg ? -q_sx : q_sx);
    assign last = ({1'b0, r_r} == h_eff - 1'b1) && ({1'b0, r_c} == w_eff - 1'b1);

    assign o_stat.out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_row    <= POS_W'(r_r - 1'b1);
            o_out_col    <= POS_W'(r_c - 1'b1);
            o_value      <= val;
            o_frame_last <= last;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cnv_chk.sv =====
// Port-level checker for the convolution block, bound to the top level.
`default_nettype none
module cnv_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic [cnv_pkg::PIX_W-1:0]      i_pixel,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [cnv_pkg::POS_W-1:0]      o_out_row,
    input wire logic [cnv_pkg::POS_W-1:0]      o_out_col,
    input wire logic signed [cnv_pkg::VAL_W-1:0] o_value,
    input wire logic                           o_frame_last,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [cnv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [cnv_pkg::KROW_W-1:0]     i_cfg_data
);
    import cnv_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_value) && $stable(o_out_row)
            && $stable(o_out_col) && $stable(o_frame_last))
        else $error("output payload changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second pixel taken before the first was processed");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_row != '0) && (o_out_col != '0))
        else $error("border position emitted");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_value) <= VAL_MAX) && ($signed(o_value) >= -VAL_MAX))
        else $error("normalized value out of range");

endmodule

bind conv3x3_normalized_stream cnv_chk u_chk (.*);
`default_nettype wire
